>>> sv/base64_stream_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Concurrent property shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// next-cycle implication
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

>>> sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Character codes, alphabet decode and shared types.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64d_sym_t;

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  n;
    logic        has;
    logic        status;
    logic        last;
  } b64d_grp_t;

  function automatic b64d_sym_t b64d_sym(input logic [7:0] c, input logic url);
    b64d_sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    priority if (c >= "A" && c <= "Z") begin
      s.val = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      s.val = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      s.val = 6'(c - "0" + 8'd52);
    end else if ((url && c == CH_DASH) || (!url && c == CH_PLUS)) begin
      s.val = 6'd62;
    end else if ((url && c == CH_UNDER) || (!url && c == CH_SLASH)) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> sv/b64d_if.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder channels
// Valid/ready interfaces for the character and byte streams.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       status;
  logic       message_end;

  modport source (output valid, output out_byte, output has_byte, output status,
                  output message_end, input ready);
  modport sink (input valid, input out_byte, input has_byte, input status,
                input message_end, output ready);
endinterface

>>> sv/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one character per word into a stream of byte words.
// ----------------------------------------------------------------------------
// One character word is taken per cycle while in_ch.ready is high. Whitespace,
// padding and characters inside a partial group produce no output and never
// stall the input. A word that completes a group of four, or ends a message,
// loads up to three output words into a single output buffer that drains one
// word per cycle while out_ch.ready is high; the input is held off until that
// buffer is empty or about to be. The alphabet select is written through
// cfg_we/cfg_wdata and kept across messages. The last output word of every
// message carries message_end and the final status.
module base64_stream_decoder_top
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);

  logic        alpha_url;
  logic [23:0] acc;
  logic [1:0]  sym_cnt;
  logic        stopped;
  logic        err_seen;

  logic [23:0] acc_next;
  logic [1:0]  sym_cnt_next;
  logic        stopped_next;
  logic        err_seen_next;

  logic [23:0] obuf;
  logic [1:0]  ocnt;
  logic        ohas;
  logic        ostatus;
  logic        oend;

  b64d_sym_t   sym;
  b64d_grp_t   grp;
  logic        accept;
  logic        pop;
  logic        skip;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  assign in_ch.ready = (ocnt == 2'd0) || (ocnt == 2'd1 && out_ch.ready);

  assign sym  = b64d_sym(in_ch.char_in, alpha_url);
  assign skip = stopped || in_ch.char_in == CH_SPACE || in_ch.char_in == CH_LF ||
                in_ch.char_in == CH_CR;

  always_comb begin
    acc_next      = acc;
    sym_cnt_next  = sym_cnt;
    stopped_next  = stopped;
    err_seen_next = err_seen;
    grp           = '0;
    grp.has       = 1'b1;
    if (!skip) begin
      priority if (in_ch.char_in == CH_PAD) begin
        if (sym_cnt >= 2'd2) begin
          stopped_next = 1'b1;
        end else begin
          acc_next     = {acc[17:0], 6'd0};
          sym_cnt_next = 2'(sym_cnt + 2'd1);
        end
      end else if (!sym.ok) begin
        err_seen_next = 1'b1;
        stopped_next  = 1'b1;
      end else if (sym_cnt == 2'd3) begin
        grp.bytes    = {acc[17:0], sym.val};
        grp.n        = 2'd3;
        acc_next     = '0;
        sym_cnt_next = 2'd0;
      end else begin
        acc_next     = {acc[17:0], sym.val};
        sym_cnt_next = 2'(sym_cnt + 2'd1);
      end
    end
    grp.status = err_seen_next;
    grp.last   = in_ch.last_char;
    if (in_ch.last_char) begin
      if (!err_seen_next) begin
        if (sym_cnt_next == 2'd3) begin
          grp.bytes = {acc_next[17:10], acc_next[9:2], 8'h00};
          grp.n     = 2'd2;
        end else if (sym_cnt_next == 2'd2) begin
          grp.bytes = {acc_next[11:4], 16'h0000};
          grp.n     = 2'd1;
        end
      end
      if (grp.n == 2'd0) begin
        grp.n   = 2'd1;
        grp.has = 1'b0;
      end
      acc_next      = '0;
      sym_cnt_next  = 2'd0;
      stopped_next  = 1'b0;
      err_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_url <= 1'b0;
      acc       <= '0;
      sym_cnt   <= 2'd0;
      stopped   <= 1'b0;
      err_seen  <= 1'b0;
      ocnt      <= 2'd0;
    end else begin
      if (cfg_we) begin
        alpha_url <= cfg_wdata;
      end
      if (accept) begin
        acc      <= acc_next;
        sym_cnt  <= sym_cnt_next;
        stopped  <= stopped_next;
        err_seen <= err_seen_next;
      end
      if (accept && grp.n != 2'd0) begin
        ocnt <= grp.n;
      end else if (pop) begin
        ocnt <= 2'(ocnt - 2'd1);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept && grp.n != 2'd0) begin
      obuf    <= grp.bytes;
      ohas    <= grp.has;
      ostatus <= grp.status;
      oend    <= grp.last;
    end else if (pop) begin
      obuf <= {obuf[15:0], 8'h00};
    end
  end

  assign out_ch.valid       = ocnt != 2'd0;
  assign out_ch.out_byte    = obuf[23:16];
  assign out_ch.has_byte    = ohas;
  assign out_ch.status      = ostatus;
  assign out_ch.message_end = oend && ocnt == 2'd1;

endmodule

>>> sv/b64d_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_assert.svh"

module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       status,
  input logic       message_end
);

  `B64D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(message_end))
  `B64D_ASSERT_NOW(a_empty_is_end, out_valid && !has_byte, message_end)
  `B64D_ASSERT_NOW(a_byte_no_error, out_valid && has_byte, !status)
  `B64D_ASSERT_NOW(a_stall_needs_out, !in_ready, out_valid)

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .has_byte    (out_ch.has_byte),
  .status      (out_ch.status),
  .message_end (out_ch.message_end)
);
